/* rtl/core/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and helpers for the multichannel step sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int CHANNELS   = 8;
    localparam int STEPS      = 16;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int POS_W      = $clog2(STEPS);
    localparam int ADDR_W     = CH_W + POS_W;
    localparam int ENTRIES    = CHANNELS * STEPS;
    localparam int VAL_W      = 15;
    localparam int DIV_W      = 3;
    localparam int RND_W      = 16;
    localparam int SPREAD_W   = 9;
    localparam int BIAS_W     = 14;
    localparam int CFG_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_SHIFT  = 8;
    localparam int DIV_ROUND  = 128;

    localparam logic [SPREAD_W-1:0]     SPREAD_MAX   = 9'd256;
    localparam logic [SPREAD_W-1:0]     SPREAD_RESET = 9'd128;
    localparam logic signed [VAL_W:0]   MV_LOW       = -16'sd5000;
    localparam logic signed [VAL_W:0]   MV_HIGH      = 16'sd10000;

    typedef enum logic [2:0] {
        CMD_CLOCK,
        CMD_SAMPLE,
        CMD_WRITE,
        CMD_CLEAR,
        CMD_GLIDE,
        CMD_FREEZE,
        CMD_DIR,
        CMD_RESET_POS
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_FWD,
        DIR_REV,
        DIR_PEND,
        DIR_RAND
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPREAD,
        CFG_BIAS
    } t_cfg_idx;

    // per-channel state word
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             head;   // 1 upward
        t_dir             dir;
        logic             frz;
        logic [DIV_W-1:0] div;
    } t_chan;

    localparam t_chan CHAN_RESET = '{pos: '0, head: 1'b1, dir: DIR_FWD, frz: 1'b0, div: '0};

    // step store write side
    typedef struct packed {
        logic                    val_we;
        logic                    glide_we;
        logic                    clr;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] val;
        logic                    glide;
    } t_step_wr;

    function automatic logic signed [VAL_W-1:0] clamp_mv(input logic signed [VAL_W:0] v);
        logic signed [VAL_W:0] c;
        c = v;
        if (v < MV_LOW) begin
            c = MV_LOW;
        end else if (v > MV_HIGH) begin
            c = MV_HIGH;
        end
        return c[VAL_W-1:0];
    endfunction

endpackage

/* rtl/core/mss_step_store.sv */
// ----------------------------------------------------------------------------
// mss_step_store
// Step value and glide memory, one row per channel, registered read,
// write-first on a same-cycle hit. Valid bits give the all-zero reset and
// the row clear of step values.
// ----------------------------------------------------------------------------
module mss_step_store
    import mss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_step_wr                i_wr,
    input  logic [ADDR_W-1:0]       i_raddr,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_glide
);

    logic signed [VAL_W-1:0] r_val_mem   [ENTRIES];
    logic                    r_glide_mem [ENTRIES];
    logic [ENTRIES-1:0]      r_val_ok;
    logic [ENTRIES-1:0]      r_glide_ok;
    logic signed [VAL_W-1:0] r_rd_val;
    logic                    r_rd_glide;
    logic [CH_W-1:0]         clr_row;
    logic [ENTRIES-1:0]      row_mask;
    logic                    hit;

    assign clr_row  = i_wr.addr[ADDR_W-1 -: CH_W];
    assign row_mask = ENTRIES'({STEPS{1'b1}}) << {clr_row, POS_W'(0)};
    assign hit      = (i_wr.addr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_ok   <= '0;
            r_glide_ok <= '0;
        end else begin
            if (i_wr.clr) begin
                r_val_ok <= r_val_ok & ~row_mask;
            end else if (i_wr.val_we) begin
                r_val_ok[i_wr.addr] <= 1'b1;
            end
            if (i_wr.glide_we) begin
                r_glide_ok[i_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_wr.addr] <= i_wr.val;
        end
        if (i_wr.glide_we) begin
            r_glide_mem[i_wr.addr] <= i_wr.glide;
        end

        if (i_wr.val_we && hit) begin
            r_rd_val <= i_wr.val;
        end else if (i_wr.clr && (i_raddr[ADDR_W-1 -: CH_W] == clr_row)) begin
            r_rd_val <= '0;
        end else if (r_val_ok[i_raddr]) begin
            r_rd_val <= r_val_mem[i_raddr];
        end else begin
            r_rd_val <= '0;
        end

        if (i_wr.glide_we && hit) begin
            r_rd_glide <= i_wr.glide;
        end else if (r_glide_ok[i_raddr]) begin
            r_rd_glide <= r_glide_mem[i_raddr];
        end else begin
            r_rd_glide <= 1'b0;
        end
    end

    assign o_val   = r_rd_val;
    assign o_glide = r_rd_glide;

endmodule

/* rtl/core/mss_chan_store.sv */
// ----------------------------------------------------------------------------
// mss_chan_store
// Per-channel state memory: position, heading, direction, freeze and divider
// count. Registered read; unwritten entries read as the reset word.
// ----------------------------------------------------------------------------
module mss_chan_store
    import mss_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [CH_W-1:0] i_waddr,
    input  t_chan           i_wdata,
    input  logic [CH_W-1:0] i_raddr,
    output t_chan           o_rdata
);

    t_chan                r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_ok;
    t_chan                r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_we) begin
            r_ok[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_ok[i_raddr] ? r_mem[i_raddr] : CHAN_RESET;
    end

    assign o_rdata = r_rd;

endmodule

/* rtl/core/mss_chan_next.sv */
// ----------------------------------------------------------------------------
// mss_chan_next
// Next channel state for one command: clock divider, direction stepping,
// freeze, direction and position resets.
// ----------------------------------------------------------------------------
module mss_chan_next
    import mss_pkg::*;
(
    input  t_cmd                i_cmd,
    input  logic [CH_W-1:0]     i_ch,
    input  t_chan               i_cs,
    input  logic [SPREAD_W-1:0] i_spread,
    input  t_dir                i_new_dir,
    input  logic [RND_W-1:0]    i_rnd,
    output t_chan               o_cs
);

    localparam int PROD_W = SPREAD_W + CH_W;
    localparam int CMP_W  = (DIV_W > CH_W ? DIV_W : CH_W) + 1;
    localparam int RPR_W  = RND_W + POS_W + 1;

    logic [SPREAD_W-1:0] spread_c;
    logic [PROD_W-1:0]   prod;
    logic [CMP_W-1:0]    divisor;
    logic [CMP_W-1:0]    cnt;
    logic [RPR_W-1:0]    rprod;
    logic [POS_W:0]      pp;
    t_chan               adv;

    assign spread_c = (i_spread > SPREAD_MAX) ? SPREAD_MAX : i_spread;
    assign prod     = PROD_W'(spread_c) * PROD_W'(i_ch) + PROD_W'(DIV_ROUND);
    assign divisor  = CMP_W'(prod >> DIV_SHIFT) + CMP_W'(1);
    assign cnt      = CMP_W'(i_cs.div) + CMP_W'(1);
    assign rprod    = RPR_W'(i_rnd) * RPR_W'(STEPS);

    always_comb begin
        adv = i_cs;
        pp  = '0;
        case (i_cs.dir)
            DIR_FWD: begin
                adv.pos = (i_cs.pos == POS_W'(STEPS - 1)) ? '0 : i_cs.pos + POS_W'(1);
            end
            DIR_REV: begin
                adv.pos = (i_cs.pos == '0) ? POS_W'(STEPS - 1) : i_cs.pos - POS_W'(1);
            end
            DIR_PEND: begin
                if (i_cs.head) begin
                    pp = (POS_W + 1)'(i_cs.pos) + (POS_W + 1)'(1);
                end else begin
                    pp = (i_cs.pos == '0) ? '0 : (POS_W + 1)'(i_cs.pos) - (POS_W + 1)'(1);
                end
                if (pp >= (POS_W + 1)'(STEPS - 1)) begin
                    pp       = (POS_W + 1)'(STEPS - 1);
                    adv.head = 1'b0;
                end
                if (pp == '0) begin
                    adv.head = 1'b1;
                end
                adv.pos = pp[POS_W-1:0];
            end
            default: begin
                adv.pos = rprod[RND_W +: POS_W];
            end
        endcase
    end

    always_comb begin
        o_cs = i_cs;
        unique case (i_cmd)
            CMD_CLOCK: begin
                if (!i_cs.frz) begin
                    if (cnt >= divisor) begin
                        o_cs     = adv;
                        o_cs.div = '0;
                    end else begin
                        o_cs.div = cnt[DIV_W-1:0];
                    end
                end
            end
            CMD_SAMPLE: begin
                if (!i_cs.frz) begin
                    o_cs = adv;
                end
            end
            CMD_RESET_POS: begin
                o_cs.pos = '0;
                o_cs.div = '0;
            end
            CMD_CLEAR: begin
                o_cs.pos = '0;
            end
            CMD_FREEZE: begin
                o_cs.frz = ~i_cs.frz;
            end
            CMD_DIR: begin
                o_cs.dir = i_new_dir;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/multichannel_step_sequencer_core.sv */
// ----------------------------------------------------------------------------
// multichannel_step_sequencer_core
// Eight-channel, sixteen-step sequencer built around a step value/glide
// memory and a per-channel state memory.
// ----------------------------------------------------------------------------
// Each visited channel passes through the fetch, update and output states:
// fetch reads its state word, update computes it and writes it back while the
// step memory is read at the new position, then output emits. Clock tick,
// sample tick and reset positions visit all eight channels in order (eight
// words); the other commands visit one channel (one word). A command is taken
// when start is high and busy low. Words appear on the o_ ports in the cycle
// after their output state, marked by o_strobe for a single cycle; the last word of
// a command carries o_last and shows in the cycle where busy has already
// dropped, so the next command may start there. No clearing pass follows reset;
// step values read as zero and channel states as the reset word until written.
// ----------------------------------------------------------------------------
module multichannel_step_sequencer_core
    import mss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_command,
    input  logic [2:0]              i_channel,
    input  logic signed [14:0]      i_value_mv,
    input  logic [1:0]              i_new_direction,
    input  logic [15:0]             i_random_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    output logic                    o_strobe,
    output logic [2:0]              o_out_channel,
    output logic [3:0]              o_position,
    output logic signed [14:0]      o_step_value_mv,
    output logic                    o_glide_flag,
    output logic                    o_frozen_flag,
    output logic [1:0]              o_direction_mode,
    output logic                    o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_UPD,
        S_OUT
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [CH_W-1:0]         r_ch;
    logic                    r_all;
    logic signed [VAL_W-1:0] r_val;
    t_dir                    r_dir;
    logic [RND_W-1:0]        r_rnd;
    t_chan                   r_cs;
    logic [SPREAD_W-1:0]     r_spread;
    logic signed [BIAS_W-1:0] r_bias;

    logic                    r_strobe;
    logic [CH_W-1:0]         r_o_ch;
    logic [POS_W-1:0]        r_o_pos;
    logic signed [VAL_W-1:0] r_o_val;
    logic                    r_o_glide;
    logic                    r_o_frz;
    t_dir                    r_o_dir;
    logic                    r_o_last;

    t_chan                   cs_rd;
    t_chan                   cs_nx;
    t_step_wr                step_wr;
    logic [ADDR_W-1:0]       step_raddr;
    logic signed [VAL_W-1:0] rd_val;
    logic                    rd_glide;
    logic signed [VAL_W:0]   samp_sum;
    logic signed [VAL_W-1:0] samp_v;
    logic signed [VAL_W-1:0] write_v;
    logic                    is_last;
    logic                    cs_we;

    mss_chan_store u_chan_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (cs_we),
        .i_waddr (r_ch),
        .i_wdata (cs_nx),
        .i_raddr (r_ch),
        .o_rdata (cs_rd)
    );

    mss_chan_next u_chan_next (
        .i_cmd     (r_cmd),
        .i_ch      (r_ch),
        .i_cs      (cs_rd),
        .i_spread  (r_spread),
        .i_new_dir (r_dir),
        .i_rnd     (r_rnd),
        .o_cs      (cs_nx)
    );

    mss_step_store u_step_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (step_wr),
        .i_raddr (step_raddr),
        .o_val   (rd_val),
        .o_glide (rd_glide)
    );

    assign samp_sum   = $signed({r_val[VAL_W-1], r_val}) + (VAL_W + 1)'(r_bias);
    assign samp_v     = clamp_mv(samp_sum);
    assign write_v    = clamp_mv($signed({r_val[VAL_W-1], r_val}));
    assign step_raddr = {r_ch, cs_nx.pos};
    assign cs_we      = (r_state == S_UPD);
    assign is_last    = !r_all || (r_ch == CH_W'(CHANNELS - 1));

    always_comb begin
        step_wr          = '0;
        step_wr.addr     = {r_ch, cs_rd.pos};
        step_wr.val      = (r_cmd == CMD_SAMPLE) ? samp_v : write_v;
        step_wr.glide    = ~rd_glide;
        unique case (r_state)
            S_UPD: begin
                step_wr.val_we = (r_cmd == CMD_WRITE) || ((r_cmd == CMD_SAMPLE) && !cs_rd.frz);
                step_wr.clr    = (r_cmd == CMD_CLEAR);
            end
            S_OUT: begin
                step_wr.addr     = {r_ch, r_cs.pos};
                step_wr.glide_we = (r_cmd == CMD_GLIDE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_spread <= SPREAD_RESET;
            r_bias   <= '0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SPREAD: r_spread <= i_cfg_wdata[SPREAD_W-1:0];
                    CFG_BIAS:   r_bias   <= i_cfg_wdata[BIAS_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= t_cmd'(i_command);
                        r_val <= i_value_mv;
                        r_dir <= t_dir'(i_new_direction);
                        r_rnd <= i_random_value;
                        case (t_cmd'(i_command)) inside
                            CMD_CLOCK, CMD_SAMPLE, CMD_RESET_POS: begin
                                r_all <= 1'b1;
                                r_ch  <= '0;
                            end
                            default: begin
                                r_all <= 1'b0;
                                r_ch  <= i_channel;
                            end
                        endcase
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_cs    <= cs_nx;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_strobe  <= 1'b1;
                    r_o_ch    <= r_ch;
                    r_o_pos   <= r_cs.pos;
                    r_o_val   <= rd_val;
                    r_o_glide <= (r_cmd == CMD_GLIDE) ? ~rd_glide : rd_glide;
                    r_o_frz   <= r_cs.frz;
                    r_o_dir   <= r_cs.dir;
                    r_o_last  <= is_last;
                    if (is_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ch    <= r_ch + CH_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_out_channel    = r_o_ch;
    assign o_position       = r_o_pos;
    assign o_step_value_mv  = r_o_val;
    assign o_glide_flag     = r_o_glide;
    assign o_frozen_flag    = r_o_frz;
    assign o_direction_mode = r_o_dir;
    assign o_last           = r_o_last;

endmodule

/* rtl/core/mss_checker.sv */
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks on command acceptance and result word sequencing.
// ----------------------------------------------------------------------------
module mss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_last,
    input logic [2:0] o_out_channel
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high on final word");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("idle before final word");

    a_next_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> ##3
            (o_strobe && (o_out_channel == $past(o_out_channel, 3) + 3'd1)))
        else $error("channel sweep out of order");

endmodule

bind multichannel_step_sequencer_core mss_checker u_mss_checker (.*);
